FILE: rtl/slpg_pkg.sv
// Package for the status LED pattern generator: codes, field widths and timing constants.
package slpg_pkg;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int FLAGS_W = 5;
    localparam int TIME_W  = 32;
    localparam int MODE_W  = 3;
    localparam int PAT_W   = 3;

    // Commands carried by an input transaction
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 2'd0,
        CMD_SET       = 2'd1,
        CMD_CLEAR     = 2'd2,
        CMD_CLEAR_ALL = 2'd3
    } t_cmd;

    // LED patterns, also the encoding of the green override register
    typedef enum logic [PAT_W-1:0] {
        PAT_OFF    = 3'd0,
        PAT_ON     = 3'd1,
        PAT_SLOW   = 3'd2,
        PAT_FAST   = 3'd3,
        PAT_DOUBLE = 3'd4
    } t_pattern;

    // Motion modes; codes above MODE_FALLEN are unknown
    localparam logic [MODE_W-1:0] MODE_BALANCE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DISARMED = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FAULT    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FALLEN   = 3'd3;

    // Flag bit positions
    localparam int FLAG_FAULT     = 0;
    localparam int FLAG_FALLEN    = 1;
    localparam int FLAG_TIMEOUT   = 2;
    localparam int FLAG_SATURATED = 3;
    localparam int FLAG_TELEM     = 4;

    // Pattern timing in milliseconds
    localparam int unsigned SLOW_MS   = 1000;
    localparam int unsigned FAST_MS   = 250;
    localparam int unsigned FLASH_MS  = 100;
    localparam int unsigned PAUSE_MS  = 600;
    localparam int unsigned DOUBLE_MS = 2 * FLASH_MS + 2 * FLASH_MS + PAUSE_MS;
    localparam int unsigned ALT_MS    = 500;

    // Common period: every pattern period divides it
    localparam int unsigned BASE_MS = SLOW_MS;
    localparam int REM_W  = $clog2(BASE_MS);
    localparam int DIFF_W = REM_W + 1;

    // Reciprocal of the common period, scaled by two to the RECIP_SHIFT
    localparam int RECIP_SHIFT = 40;
    localparam int RECIP_W     = 31;
    localparam int PROD_W      = TIME_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_BASE =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(BASE_MS));

endpackage

FILE: rtl/slpg_item_if.sv
// Input channel of the status LED pattern generator: handshake and command payload.
interface slpg_item_if
    import slpg_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [FLAGS_W-1:0] flag_mask;
    logic [TIME_W-1:0]  now_ms;
    logic [MODE_W-1:0]  motion_mode;

    modport source (output valid, command, flag_mask, now_ms, motion_mode, input ready);
    modport sink   (input valid, command, flag_mask, now_ms, motion_mode, output ready);
endinterface

FILE: rtl/slpg_result_if.sv
// Result channel of the status LED pattern generator: handshake and LED/flag payload.
interface slpg_result_if
    import slpg_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               green_led;
    logic               red_on;
    logic [FLAGS_W-1:0] flags_now;

    modport source (output valid, green_led, red_on, flags_now, input ready);
    modport sink   (input valid, green_led, red_on, flags_now, output ready);
endinterface

FILE: rtl/status_led_pattern_generator.sv
// Top level of the status LED pattern generator: pipelined time reduction and LED logic.
//
// Each input transaction yields exactly one result transaction, in order. A new transaction
// is accepted every cycle while the result side is not stalled. Reducing now_ms modulo
// 1000 ms sets the pipeline depth: a reciprocal multiply into stage 2, a remainder correction
// into stage 3, then the pattern and flag logic that writes the state and the result register
// together. Flag commands update the flag register and repeat the LED levels of the last
// tick. The user must write the green override through i_cfg_we/i_cfg_wdata only while
// no transaction is in flight; the block itself does not enforce this.
module status_led_pattern_generator
    import slpg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    slpg_item_if.sink          i_item,
    slpg_result_if.source      o_result,
    input  logic               i_cfg_we,
    input  logic [PAT_W-1:0]   i_cfg_wdata
);

    // Stage 1: input register
    logic               r_v1;
    t_cmd               r_s1_cmd;
    logic [FLAGS_W-1:0] r_s1_mask;
    logic [TIME_W-1:0]  r_s1_now;
    logic [MODE_W-1:0]  r_s1_mode;

    // Stage 2: quotient estimate
    logic               r_v2;
    t_cmd               r_s2_cmd;
    logic [FLAGS_W-1:0] r_s2_mask;
    logic [DIFF_W-1:0]  r_s2_now_lo;
    logic [MODE_W-1:0]  r_s2_mode;
    logic [QUOT_W-1:0]  r_s2_quot;

    // Stage 3: time modulo the common period
    logic               r_v3;
    t_cmd               r_s3_cmd;
    logic [FLAGS_W-1:0] r_s3_mask;
    logic [MODE_W-1:0]  r_s3_mode;
    logic [REM_W-1:0]   r_s3_rem;

    // State, which is also the result register
    logic               r_out_valid;
    logic [FLAGS_W-1:0] r_flags;
    logic [1:0]         r_leds;
    logic [PAT_W-1:0]   r_override;
    logic [FLAGS_W-1:0] n_flags;
    logic [1:0]         n_leds;

    logic w_adv_out;
    logic w_rdy3;
    logic w_rdy2;
    logic w_rdy1;
    logic w_fire;

    // Ready chain: a stage loads when it is empty or its contents move on
    assign w_adv_out    = !r_out_valid || o_result.ready;
    assign w_rdy3       = !r_v3 || w_adv_out;
    assign w_rdy2       = !r_v2 || w_rdy3;
    assign w_rdy1       = !r_v1 || w_rdy2;
    assign w_fire       = r_v3 && w_adv_out;
    assign i_item.ready = w_rdy1;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_override <= PAT_OFF;
        end else if (i_cfg_we) begin
            r_override <= i_cfg_wdata;
        end
    end

    // Valid bits of the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_item.valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_adv_out) begin
                r_out_valid <= r_v3;
            end
        end
    end

    // Stage 1: capture the transaction
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_cmd  <= t_cmd'(i_item.command);
            r_s1_mask <= i_item.flag_mask;
            r_s1_now  <= i_item.now_ms;
            r_s1_mode <= i_item.motion_mode;
        end
    end

    // Stage 2: estimate now_ms / BASE_MS, low by at most one
    logic [PROD_W-1:0] w_prod;

    assign w_prod = PROD_W'(r_s1_now) * PROD_W'(RECIP_BASE);

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_s2_cmd    <= r_s1_cmd;
            r_s2_mask   <= r_s1_mask;
            r_s2_mode   <= r_s1_mode;
            r_s2_now_lo <= r_s1_now[DIFF_W-1:0];
            r_s2_quot   <= w_prod[PROD_W-1:RECIP_SHIFT];
        end
    end

    // Stage 3: subtract quotient times period, correct once; only low bits matter
    logic [2*DIFF_W-1:0] w_qk;
    logic [DIFF_W-1:0]   w_diff;
    logic [DIFF_W-1:0]   w_rem;

    assign w_qk   = (2*DIFF_W)'(r_s2_quot[DIFF_W-1:0]) * (2*DIFF_W)'(BASE_MS);
    assign w_diff = r_s2_now_lo - w_qk[DIFF_W-1:0];
    assign w_rem  = (w_diff >= DIFF_W'(BASE_MS)) ? (w_diff - DIFF_W'(BASE_MS)) : w_diff;

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_s3_cmd  <= r_s2_cmd;
            r_s3_mask <= r_s2_mask;
            r_s3_mode <= r_s2_mode;
            r_s3_rem  <= w_rem[REM_W-1:0];
        end
    end

    // Phase of each pattern from the reduced time
    logic [REM_W-1:0] w_e500;
    logic [REM_W-1:0] w_e250;
    logic             w_slow_lit;
    logic             w_fast_lit;
    logic             w_alt_lit;
    logic             w_dbl_lit;

    assign w_e500 = (r_s3_rem >= REM_W'(ALT_MS)) ? (r_s3_rem - REM_W'(ALT_MS)) : r_s3_rem;
    assign w_e250 = (w_e500 >= REM_W'(FAST_MS)) ? (w_e500 - REM_W'(FAST_MS)) : w_e500;
    assign w_slow_lit = r_s3_rem < REM_W'(SLOW_MS / 2);
    assign w_fast_lit = w_e250 < REM_W'(FAST_MS / 2);
    assign w_alt_lit  = w_e500 < REM_W'(ALT_MS / 2);
    assign w_dbl_lit  = (r_s3_rem < REM_W'(FLASH_MS)) ||
                        ((r_s3_rem >= REM_W'(2 * FLASH_MS)) &&
                         (r_s3_rem < REM_W'(3 * FLASH_MS)));

    function automatic logic lit_for(input logic [PAT_W-1:0] pat, input logic slow,
                                     input logic fast, input logic dbl);
        logic lit;
        case (pat)
            PAT_ON:     lit = 1'b1;
            PAT_SLOW:   lit = slow;
            PAT_FAST:   lit = fast;
            PAT_DOUBLE: lit = dbl;
            default:    lit = 1'b0;
        endcase
        return lit;
    endfunction

    // Pattern selection for both LEDs
    logic [PAT_W-1:0] w_green_pat;
    logic [PAT_W-1:0] w_red_pat;

    always_comb begin
        if (r_override != PAT_OFF) begin
            w_green_pat = r_override;
        end else begin
            case (r_s3_mode) inside
                MODE_BALANCE:              w_green_pat = PAT_ON;
                MODE_DISARMED:             w_green_pat = PAT_SLOW;
                MODE_FAULT, MODE_FALLEN:   w_green_pat = PAT_OFF;
                default:                   w_green_pat = PAT_FAST;
            endcase
        end

        if (r_flags[FLAG_FAULT] || r_flags[FLAG_FALLEN]) begin
            w_red_pat = PAT_ON;
        end else if (r_flags[FLAG_TIMEOUT]) begin
            w_red_pat = PAT_FAST;
        end else if (r_flags[FLAG_SATURATED]) begin
            w_red_pat = PAT_SLOW;
        end else begin
            w_red_pat = PAT_OFF;
        end
    end

    // Next flags and LED levels; hold unless a transaction retires
    always_comb begin
        n_flags = r_flags;
        n_leds  = r_leds;
        if (w_fire) begin
            case (r_s3_cmd)
                CMD_TICK: begin
                    if (r_flags[FLAG_TELEM]) begin
                        n_leds = {!w_alt_lit, w_alt_lit};
                    end else begin
                        n_leds = {lit_for(w_red_pat, w_slow_lit, w_fast_lit, w_dbl_lit),
                                  lit_for(w_green_pat, w_slow_lit, w_fast_lit, w_dbl_lit)};
                    end
                end
                CMD_SET:   n_flags = r_flags | r_s3_mask;
                CMD_CLEAR: n_flags = r_flags & ~r_s3_mask;
                default:   n_flags = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_leds  <= '0;
        end else begin
            r_flags <= n_flags;
            r_leds  <= n_leds;
        end
    end

    // Drive the result channel straight from the state
    assign o_result.valid     = r_out_valid;
    assign o_result.green_led = r_leds[0];
    assign o_result.red_on    = r_leds[1];
    assign o_result.flags_now = r_flags;

    // Checks
    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_s3_cmd == CMD_CLEAR_ALL) |=> (r_flags == '0))
        else $error("flags not cleared by clear-all");

    a_hold_leds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_s3_cmd != CMD_TICK) |=> $stable(r_leds))
        else $error("LED levels changed on a flag command");

    a_telem_alt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_s3_cmd == CMD_TICK && r_flags[FLAG_TELEM]) |=>
        (o_result.green_led != o_result.red_on))
        else $error("telemetry failure pattern not alternating");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r_s3_rem < REM_W'(BASE_MS)))
        else $error("time remainder out of range");

endmodule
